FILE: hw/rtl/apq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants for the array priority queue
// Field widths, request/result codes and the result record handed between
// the queue engine and the top level.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned ENTRY_W   = TAG_W + PRIO_W;
  localparam int unsigned FILL_W    = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OUT_W     = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SERVE  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [TAG_W-1:0]    tag;
    logic [PRIO_W-1:0]   prio;
    logic [FILL_W-1:0]   fill;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/apq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output      logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/apq_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_engine: queue sequencer
// Holds the entry count, appends on insert, scans the entry RAM for the
// smallest priority on serve and then closes the gap by moving the later
// entries up one place, one RAM read and one write per cycle.
// ----------------------------------------------------------------------------
module apq_engine #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEF,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output      logic                          req_ready_o,
  input  wire logic                          op_i,
  input  wire logic [apq_pkg::TAG_W-1:0]     tag_i,
  input  wire logic [apq_pkg::PRIO_W-1:0]    prio_i,
  output      logic                          res_valid_o,
  input  wire logic                          res_ready_i,
  output      apq_pkg::res_t                 res_o,
  output      logic                          ram_wr_en_o,
  output      logic [AW-1:0]                 ram_wr_addr_o,
  output      logic [apq_pkg::ENTRY_W-1:0]   ram_wr_data_o,
  output      logic                          ram_rd_en_o,
  output      logic [AW-1:0]                 ram_rd_addr_o,
  input  wire logic [apq_pkg::ENTRY_W-1:0]   ram_rd_data_i
);
  import apq_pkg::*;

  localparam int unsigned CW1 = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;       // scan read pointer / shift write pointer
  logic [CNT_W-1:0]    best_idx_q, best_idx_d;
  logic [TAG_W-1:0]    best_tag_q, best_tag_d;
  logic [PRIO_W-1:0]   best_prio_q, best_prio_d;
  status_e             status_q, status_d;

  logic [TAG_W-1:0]    rd_tag;
  logic [PRIO_W-1:0]   rd_prio;
  logic [CNT_W-1:0]    cand_idx;
  logic                take;
  logic [CNT_W-1:0]    best_idx_n;
  logic [CW1-1:0]      after_best;
  logic [CW1-1:0]      ptr_plus2;

  // Entry layout: tag in the upper bits, priority in the lower bits
  assign rd_tag  = ram_rd_data_i[ENTRY_W-1:PRIO_W];
  assign rd_prio = ram_rd_data_i[PRIO_W-1:0];

  assign cand_idx   = ptr_q - CNT_W'(1);
  // First entry always seeds the minimum; strict compare keeps the oldest
  assign take       = (ptr_q == CNT_W'(1)) || (rd_prio < best_prio_q);
  assign best_idx_n = take ? cand_idx : best_idx_q;
  assign after_best = {1'b0, best_idx_n} + CW1'(1);
  assign ptr_plus2  = {1'b0, ptr_q} + CW1'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    best_idx_q  <= best_idx_d;
    best_tag_q  <= best_tag_d;
    best_prio_q <= best_prio_d;
    status_q    <= status_d;
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    best_idx_d    = best_idx_q;
    best_tag_d    = best_tag_q;
    best_prio_d   = best_prio_q;
    status_d      = status_q;
    req_ready_o   = 1'b0;
    res_valid_o   = 1'b0;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = '0;
    ram_wr_data_o = '0;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = '0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        best_tag_d  = '0;
        best_prio_d = '0;
        if (req_valid_i) begin
          if (op_i == OP_INSERT) begin
            state_d = S_RESP;
            if (count_q == CNT_FULL) begin
              status_d = ST_FULL;
            end else begin
              ram_wr_en_o   = 1'b1;
              ram_wr_addr_o = count_q[AW-1:0];
              ram_wr_data_o = {tag_i, prio_i};
              count_d       = count_q + CNT_W'(1);
              status_d      = ST_ADDED;
            end
          end else if (count_q == '0) begin
            status_d = ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            ram_rd_en_o   = 1'b1;
            ram_rd_addr_o = '0;
            ptr_d         = CNT_W'(1);
            status_d      = ST_SERVED;
            state_d       = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read data belongs to entry ptr_q - 1
        if (take) begin
          best_idx_d  = cand_idx;
          best_tag_d  = rd_tag;
          best_prio_d = rd_prio;
        end
        if (ptr_q < count_q) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = ptr_q[AW-1:0];
          ptr_d         = ptr_q + CNT_W'(1);
        end else if (after_best < {1'b0, count_q}) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = after_best[AW-1:0];
          ptr_d         = best_idx_n;
          state_d       = S_SHIFT;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end

      S_SHIFT: begin
        // read data is entry ptr_q + 1, moved down into ptr_q
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = ptr_q[AW-1:0];
        ram_wr_data_o = ram_rd_data_i;
        if (ptr_plus2 < {1'b0, count_q}) begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = ptr_plus2[AW-1:0];
          ptr_d         = ptr_q + CNT_W'(1);
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status = status_q;
  assign res_o.tag    = best_tag_q;
  assign res_o.prio   = best_prio_q;
  assign res_o.fill   = FILL_W'(count_q);

endmodule
`default_nettype wire

FILE: hw/rtl/array_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_priority_queue_top: bounded priority queue of tagged requests
// Input stream carries insert or serve requests; output stream carries one
// result per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tuser = op (0 insert, 1 serve), tdata = {prio, tag}.
//   m_axis: tuser = status (added, full, served, empty),
//           tdata = {fill, served_prio, served_tag}, served fields zero unless
//           the status is served.
//   One request is processed at a time. An insert or a rejected request goes
//   straight from idle to the result. A serve first scans the entry RAM
//   through its single read port, then moves each entry behind the winner
//   up one place.
//   The result sits in an output register, so the next request is accepted
//   while a result waits on a stalled receiver; the engine then holds its
//   finished result until the output register frees up.
//   Reset empties the queue; no RAM clearing pass is needed, only entries
//   below the count are ever read.
// ----------------------------------------------------------------------------
module array_priority_queue_top #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [apq_pkg::ENTRY_W-1:0]   s_axis_tdata,   // [15:0] tag, [23:16] prio
  input  wire logic                          s_axis_tuser,   // [0] op
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [apq_pkg::OUT_W-1:0]     m_axis_tdata,   // [15:0] served_tag,
                                                             // [23:16] served_prio,
                                                             // [28:24] fill
  output      logic [apq_pkg::STATUS_W-1:0]  m_axis_tuser    // [1:0] status
);
  import apq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic               req_ready;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  logic               out_valid_q, out_valid_d;
  res_t               out_q;

  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  apq_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (req_ready),
    .op_i          (s_axis_tuser),
    .tag_i         (s_axis_tdata[TAG_W-1:0]),
    .prio_i        (s_axis_tdata[ENTRY_W-1:TAG_W]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data)
  );

  assign s_axis_tready = req_ready;

  // output register frees when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {(OUT_W - ENTRY_W - FILL_W)'(0), out_q.fill, out_q.prio, out_q.tag};

endmodule
`default_nettype wire

FILE: hw/rtl/apq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_assert: port-level checks for the array priority queue
// Watches the stream ports of the top level only; bound in below.
// ----------------------------------------------------------------------------
module apq_assert #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [apq_pkg::OUT_W-1:0]     m_axis_tdata,
  input wire logic [apq_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import apq_pkg::*;

  logic s_acc;
  logic m_not_served;
  assign s_acc        = s_axis_tvalid && s_axis_tready;
  assign m_not_served = (m_axis_tuser == ST_ADDED) || (m_axis_tuser == ST_FULL) ||
                        (m_axis_tuser == ST_EMPTY);

  // a pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped before accept");

  // one request at a time: no back-to-back accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request accepted while previous one in progress");

  // served fields are zero unless something was served
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_not_served) |-> (m_axis_tdata[ENTRY_W-1:0] == '0))
    else $error("served fields nonzero on non-serve result");

  // an empty report leaves the queue empty
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |->
      (m_axis_tdata[ENTRY_W+FILL_W-1:ENTRY_W] == '0))
    else $error("empty status with nonzero fill");

endmodule

bind array_priority_queue_top apq_assert #(
  .DEPTH (DEPTH)
) u_apq_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
